// ===== hw/rtl/huffman_code_bit_packer_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Huffman bit packer
// Shorthand for the concurrent checks used inside the RTL modules.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH
`define HUFFMAN_CODE_BIT_PACKER_CORE_ASSERT_SVH

// The condition must never be true outside reset.
`define HCBP_ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("packer check failed: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define HCBP_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("packer check failed: same-cycle implication");

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define HCBP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("packer check failed: next-cycle implication");

`endif

// ===== hw/rtl/hcbp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared field widths, item kinds and the code table request type.
// ----------------------------------------------------------------------------
`default_nettype none

package hcbp_pkg;

  localparam int KIND_W      = 2;
  localparam int SYMBOL_W    = 8;
  localparam int CODE_WORD_W = 32;
  localparam int CODE_LEN_W  = 6;
  localparam int BYTE_W      = 8;
  localparam int PEND_W      = 7;
  localparam int PEND_CNT_W  = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD  = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_FLUSH = 2'd2
  } kind_t;

  // Request to the code table: a load writes one entry, a data word reads one.
  typedef struct packed {
    logic                   wr_en;
    logic                   rd_en;
    logic [SYMBOL_W-1:0]    symbol;
    logic [CODE_WORD_W-1:0] code_word;
    logic [CODE_LEN_W-1:0]  code_length;
  } table_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/hcbp_item_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_item_if
// Input channel: load, data and flush words with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_item_if;
  import hcbp_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [KIND_W-1:0]      kind;
  logic [SYMBOL_W-1:0]    symbol;
  logic [CODE_WORD_W-1:0] code_word;
  logic [CODE_LEN_W-1:0]  code_length;

  modport source (output valid, kind, symbol, code_word, code_length, input ready);
  modport sink   (input valid, kind, symbol, code_word, code_length, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hcbp_result_if.sv =====
// ----------------------------------------------------------------------------
// hcbp_result_if
// Output channel: one packed byte per word with a valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface hcbp_result_if;
  import hcbp_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] packed_byte;
  logic              last_of_run;

  modport source (output valid, packed_byte, last_of_run, input ready);
  modport sink   (input valid, packed_byte, last_of_run, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/hcbp_table.sv =====
// ----------------------------------------------------------------------------
// hcbp_table
// Code and length store with a registered read and per-entry loaded flags.
// ----------------------------------------------------------------------------
`default_nettype none

module hcbp_table #(
  parameter int SYMBOL_COUNT = 256,
  parameter int LEN_CAP      = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  hcbp_pkg::table_req_t              req,
  output logic [hcbp_pkg::CODE_LEN_W-1:0]   rd_length,
  output logic [LEN_CAP-1:0]                rd_code
);
  import hcbp_pkg::*;

  localparam int IDX_W = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;

  logic [LEN_CAP-1:0]    code_mem [SYMBOL_COUNT];
  logic [CODE_LEN_W-1:0] len_mem  [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] loaded;

  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic [CODE_LEN_W-1:0] len_sat;
  logic [CODE_LEN_W-1:0] rd_len_raw;
  logic                  rd_hit;

  assign in_range = 32'(req.symbol) < 32'(SYMBOL_COUNT);
  assign idx      = req.symbol[IDX_W-1:0];
  assign len_sat  = (req.code_length > CODE_LEN_W'(LEN_CAP)) ? CODE_LEN_W'(LEN_CAP)
                                                            : req.code_length;

  // The stores themselves: no reset; an unflagged entry reads back with length zero.
  always_ff @(posedge clk) begin
    if (req.wr_en && in_range) begin
      code_mem[idx] <= req.code_word[LEN_CAP-1:0];
      len_mem[idx]  <= len_sat;
    end
    if (req.rd_en) begin
      rd_code    <= code_mem[idx];
      rd_len_raw <= len_mem[idx];
    end
  end

  // Loaded flags stand in for the cleared length store.
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= '0;
      rd_hit <= 1'b0;
    end else begin
      if (req.wr_en && in_range) begin
        loaded[idx] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_hit <= in_range && loaded[idx];
      end
    end
  end

  assign rd_length = rd_hit ? rd_len_raw : '0;

endmodule

`default_nettype wire

// ===== hw/rtl/huffman_code_bit_packer_core.sv =====
// A data or flush word waits in stage one for its registered table read and then
// moves into the output byte buffer. Throughput: one input word per cycle while
// each word yields at most one byte and the receiver is ready; a word that yields
// several bytes holds the single output port until all of them have been taken.
// Reset clears the pipeline, the pending bits and the loaded flags of the table;
// the code store keeps its contents and no clearing pass is needed.
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Streaming Huffman encoder: loadable code table, bit merge and byte output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "huffman_code_bit_packer_core_assert.svh"

module huffman_code_bit_packer_core #(
  parameter int SYMBOL_COUNT = 256,
  parameter int MAX_CODE_LEN = 32
) (
  input logic           clk,
  input logic           rst,
  hcbp_item_if.sink     items,
  hcbp_result_if.source results
);
  import hcbp_pkg::*;

  // Longest stored code, limited by the width of the incoming code word.
  localparam int LEN_CAP   = (MAX_CODE_LEN > CODE_WORD_W) ? CODE_WORD_W : MAX_CODE_LEN;
  // The merge window holds the pending bits followed by one whole code.
  localparam int ACC_W     = LEN_CAP + PEND_W;
  localparam int MAX_BYTES = ACC_W / BYTE_W;
  localparam int OUT_W     = MAX_BYTES * BYTE_W;
  localparam int CNT_W     = $clog2(MAX_BYTES + 1);
  localparam int SHIFT_W   = $clog2(ACC_W + 1);

  // Handshake and stage control.
  logic item_fire;
  logic out_fire;
  logic buf_free;
  logic s1_adv;

  // Stage one: the word waiting for the merge; its table read is registered.
  logic  s1_valid;
  kind_t s1_kind;

  table_req_t            table_req;
  logic [CODE_LEN_W-1:0] tbl_len;
  logic [LEN_CAP-1:0]    tbl_code;

  // Running bit buffer and the output byte buffer.
  logic [PEND_W-1:0]     pending_bits,  pending_bits_next;
  logic [PEND_CNT_W-1:0] pending_count, pending_count_next;
  logic [OUT_W-1:0]      out_buf,       out_buf_next;
  logic [CNT_W-1:0]      out_count,     out_count_next;

  // Merge datapath.
  logic [LEN_CAP-1:0]    code_masked;
  logic [ACC_W-1:0]      acc;
  logic [ACC_W-1:0]      left;
  logic [CODE_LEN_W-1:0] total;
  logic [BYTE_W-1:0]     flush_byte;

  assign item_fire = items.valid && items.ready;
  assign out_fire  = results.valid && results.ready;

  // The merged word may move on once the byte buffer is empty or is handing
  // over its last byte in this very cycle.
  assign buf_free    = (out_count == '0) || ((out_count == CNT_W'(1)) && results.ready);
  assign s1_adv      = s1_valid && buf_free;
  assign items.ready = !s1_valid || s1_adv;

  // A load writes the table at its accept edge; a data word reads it at its
  // own accept edge, so a load followed at once by data for the same symbol
  // already sees the new entry.
  always_comb begin
    table_req             = '0;
    table_req.wr_en       = item_fire && (items.kind == KIND_LOAD);
    table_req.rd_en       = item_fire && (items.kind == KIND_DATA);
    table_req.symbol      = items.symbol;
    table_req.code_word   = items.code_word;
    table_req.code_length = items.code_length;
  end

  hcbp_table #(
    .SYMBOL_COUNT (SYMBOL_COUNT),
    .LEN_CAP      (LEN_CAP)
  ) u_table (
    .clk       (clk),
    .rst       (rst),
    .req       (table_req),
    .rd_length (tbl_len),
    .rd_code   (tbl_code)
  );

  // Only data and flush words go on to the merge; loads and the unused kind
  // finish at the accept edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= (items.kind == KIND_DATA) || (items.kind == KIND_FLUSH);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_kind <= kind_t'(items.kind);
    end
  end

  // The code is appended below the pending bits, then the whole window is
  // left-aligned so that complete bytes sit at the top, earliest bit first.
  // Whatever is left under the last full byte becomes the new pending bits.
  assign code_masked = tbl_code & ~({LEN_CAP{1'b1}} << tbl_len);
  assign acc         = (ACC_W'(pending_bits) << tbl_len) | ACC_W'(code_masked);
  assign total       = CODE_LEN_W'(pending_count) + tbl_len;
  assign left        = acc << (SHIFT_W'(ACC_W) - SHIFT_W'(total));

  // A flush pads the pending bits with zeros up to one whole byte.
  assign flush_byte  = BYTE_W'({1'b0, pending_bits} << (4'(BYTE_W) - {1'b0, pending_count}));

  always_comb begin
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    out_buf_next       = out_buf;
    out_count_next     = out_count;
    case (s1_kind)
      KIND_DATA: begin
        out_buf_next       = left[ACC_W-1 -: OUT_W];
        out_count_next     = CNT_W'(total >> 3);
        pending_count_next = total[PEND_CNT_W-1:0];
        pending_bits_next  = acc[PEND_W-1:0] & ~({PEND_W{1'b1}} << total[PEND_CNT_W-1:0]);
      end
      KIND_FLUSH: begin
        out_buf_next       = OUT_W'(flush_byte) << (OUT_W - BYTE_W);
        out_count_next     = CNT_W'(1);
        pending_count_next = '0;
        pending_bits_next  = '0;
      end
      default: begin
        out_count_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_count     <= '0;
      pending_bits  <= '0;
      pending_count <= '0;
    end else if (s1_adv) begin
      out_count     <= out_count_next;
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
    end else if (out_fire) begin
      out_count <= out_count - CNT_W'(1);
    end
  end

  // Bytes leave from the top of the buffer; each taken byte shifts the rest up.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_buf <= out_buf_next;
    end else if (out_fire) begin
      out_buf <= out_buf << BYTE_W;
    end
  end

  assign results.valid       = (out_count != '0);
  assign results.packed_byte = out_buf[OUT_W-1 -: BYTE_W];
  assign results.last_of_run = (out_count == CNT_W'(1));

  `HCBP_ASSERT_NEVER(a_count_bound, clk, rst, out_count > CNT_W'(MAX_BYTES))
  `HCBP_ASSERT_NEVER(a_pending_clean, clk, rst, (pending_bits >> pending_count) != '0)
  `HCBP_ASSERT_IMPL(a_stall_blocks_input, clk, rst, s1_valid && !buf_free, !items.ready)
  `HCBP_ASSERT_NEXT(a_flush_empties, clk, rst, s1_adv && (s1_kind == KIND_FLUSH), (pending_count == '0) && (out_count == CNT_W'(1)))
  `HCBP_ASSERT_NEXT(a_drain_step, clk, rst, out_fire && !s1_adv, out_count == $past(out_count) - CNT_W'(1))

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman code bit packer core. Code table loads,
// data words and flushes are driven over the item channel. A bit-level
// predictor works out every packed byte, and each byte taken from the result
// channel is compared against the oldest one still due.
// ----------------------------------------------------------------------------

module tb;
  import hcbp_pkg::*;

  localparam int SYMBOL_COUNT = 256;
  localparam int MAX_CODE_LEN = 32;
  // A loaded length never exceeds the width of the code word field.
  localparam int CODE_LEN_CAP = (MAX_CODE_LEN < CODE_WORD_W) ? MAX_CODE_LEN : CODE_WORD_W;
  // Kind 3 is not decoded by the block; the package gives it no name.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES   = 60;
  localparam int PHASE_WORDS   = 20;
  localparam int SETTLE_CYCLES = 20;
  localparam int TIMEOUT_NS    = 3_000_000;

  // One byte the block owes us, with its end-of-run flag.
  typedef struct {
    logic [BYTE_W-1:0] value;
    logic              last;
  } due_byte_t;

  // Bit-exact model of the packer together with the queue of bytes it owes.
  class bit_pack_predictor;
    logic [CODE_WORD_W-1:0] code_table [SYMBOL_COUNT];
    logic [CODE_LEN_W-1:0]  len_table  [SYMBOL_COUNT];
    logic [PEND_W-1:0]      held_bits;
    logic [PEND_CNT_W-1:0]  held_count;
    due_byte_t              bytes_due [$];
    int                     mismatch_count;

    function new();
      foreach (len_table[i]) len_table[i] = '0;
      held_bits      = '0;
      held_count     = '0;
      mismatch_count = 0;
    endfunction

    task report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
    endtask

    // Called once for every word accepted on the item channel.
    function void note_word(input logic [KIND_W-1:0] kind, input logic [SYMBOL_W-1:0] sym,
                            input logic [CODE_WORD_W-1:0] code,
                            input logic [CODE_LEN_W-1:0] len_in);
      logic [63:0] acc;
      logic [15:0] padded;
      int unsigned run_len;
      int unsigned total;
      due_byte_t   next_byte;
      case (kind)
        KIND_LOAD: begin
          code_table[sym] = code;
          len_table[sym]  = (len_in > CODE_LEN_CAP) ? CODE_LEN_W'(CODE_LEN_CAP) : len_in;
        end
        KIND_DATA: begin
          run_len = len_table[sym];
          // The mask is zero for an unloaded symbol, so an unwritten code is never used.
          acc = (64'(held_bits) << run_len)
              | (64'(code_table[sym]) & ((64'd1 << run_len) - 64'd1));
          total = held_count + run_len;
          while (total >= BYTE_W) begin
            next_byte.value = acc[total-1 -: BYTE_W];
            next_byte.last  = (total < 2 * BYTE_W);
            bytes_due.push_back(next_byte);
            total -= BYTE_W;
          end
          held_bits  = PEND_W'(acc & ((64'd1 << total) - 64'd1));
          held_count = PEND_CNT_W'(total);
        end
        KIND_FLUSH: begin
          padded          = 16'(held_bits) << (BYTE_W - held_count);
          next_byte.value = padded[BYTE_W-1:0];
          next_byte.last  = 1'b1;
          bytes_due.push_back(next_byte);
          held_bits  = '0;
          held_count = '0;
        end
        default: ;
      endcase
    endfunction

    // Called once for every word accepted on the result channel.
    task check_byte(input logic [BYTE_W-1:0] value, input logic last);
      due_byte_t want;
      if (bytes_due.size() == 0) begin
        report_mismatch($sformatf("byte %h arrived with nothing due", value));
      end else begin
        want = bytes_due.pop_front();
        if (value !== want.value)
          report_mismatch($sformatf("packed_byte %h, predicted %h", value, want.value));
        if (last !== want.last)
          report_mismatch($sformatf("last_of_run %b, predicted %b", last, want.last));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  hcbp_item_if   items_ch ();
  hcbp_result_if results_ch ();

  huffman_code_bit_packer_core #(
    .SYMBOL_COUNT(SYMBOL_COUNT),
    .MAX_CODE_LEN(MAX_CODE_LEN)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_ch),
    .results(results_ch)
  );

  bit_pack_predictor packer_model = new();

  // Idling odds in percent, set per phase by the stimulus process.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  // A long receiver hold-off is requested by bumping holds_asked; the sink
  // process serves it and counts the stretch itself.
  int holds_asked  = 0;
  int holds_served = 0;

  always #5 clk = ~clk;

  // Result sink. Ready changes only at rising edges, so it is stable by the
  // falling edge, where the monitor below looks at it.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        results_ch.ready <= 1'b0;
        hold_left--;
      end else if (holds_served != holds_asked) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // Everything driven by either side settles after the rising edge, so the
  // falling edge shows exactly which words will be taken at the next edge.
  always @(negedge clk) begin
    if (!rst && results_ch.valid && results_ch.ready)
      packer_model.check_byte(results_ch.packed_byte, results_ch.last_of_run);
  end

  // Offers one word and returns just after the edge that accepts it. Valid is
  // only lowered for a gap, so back-to-back words keep it high throughout.
  task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SYMBOL_W-1:0] sym,
                           input logic [CODE_WORD_W-1:0] code,
                           input logic [CODE_LEN_W-1:0] len);
    while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid       <= 1'b1;
    items_ch.kind        <= kind;
    items_ch.symbol      <= sym;
    items_ch.code_word   <= code;
    items_ch.code_length <= len;
    do @(negedge clk); while (!items_ch.ready);
    packer_model.note_word(kind, sym, code, len);
    @(posedge clk);
  endtask

  // The sender stops offering until the block has handed over every byte due.
  task automatic wait_for_bytes_out();
    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (packer_model.bytes_due.size() != 0) @(posedge clk);
  endtask

  // Random words, mostly loads and data on a small pool of symbols so that
  // codes get reused and the pending buffer sees every fill level. Data on an
  // unloaded symbol and the undecoded kind do nothing, so they are not counted.
  task automatic run_random_phase(input int word_target);
    int                     counted;
    int                     roll;
    logic [SYMBOL_W-1:0]    sym;
    logic [CODE_LEN_W-1:0]  len;
    counted = 0;
    while (counted < word_target) begin
      roll = $urandom_range(0, 99);
      sym  = ($urandom_range(0, 9) != 0) ? SYMBOL_W'($urandom_range(0, 15))
                                         : SYMBOL_W'($urandom_range(0, 255));
      if (roll < 25) begin
        case ($urandom_range(0, 9))
          0:       len = CODE_LEN_W'($urandom_range(0, 63));
          1, 2:    len = CODE_LEN_W'($urandom_range(13, 32));
          default: len = CODE_LEN_W'($urandom_range(1, 12));
        endcase
        send_word(KIND_LOAD, sym, $urandom, len);
        counted++;
      end else if (roll < 85) begin
        if (packer_model.len_table[sym] != 0) counted++;
        send_word(KIND_DATA, sym, $urandom, CODE_LEN_W'($urandom));
      end else if (roll < 97) begin
        send_word(KIND_FLUSH, SYMBOL_W'($urandom), $urandom, CODE_LEN_W'($urandom));
        counted++;
      end else begin
        send_word(KIND_UNUSED, SYMBOL_W'($urandom), $urandom, CODE_LEN_W'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    items_ch.valid       <= 1'b0;
    items_ch.kind        <= KIND_LOAD;
    items_ch.symbol      <= '0;
    items_ch.code_word   <= '0;
    items_ch.code_length <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed opening: an unloaded symbol and a flush with nothing pending,
    // then the undecoded kind, loads at the length extremes (zero, one, full
    // width and overlong), and data words that cross byte boundaries.
    send_word(KIND_DATA, 8'd7, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_word(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63);
    send_word(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd32);
    send_word(KIND_LOAD, 8'd255, 32'h0, 6'd1);
    send_word(KIND_LOAD, 8'd1, 32'h0000_00A5, 6'd8);
    send_word(KIND_LOAD, 8'd2, 32'h1234_5678, 6'd63);
    // Bits above the code length must not leak into the output.
    send_word(KIND_LOAD, 8'd3, 32'hFFFF_FF55, 6'd7);
    send_word(KIND_LOAD, 8'd4, 32'hDEAD_BEEF, 6'd0);
    send_word(KIND_LOAD, 8'd5, 32'h2AAA_AAAA, 6'd33);
    send_word(KIND_DATA, 8'd255, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd0, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd1, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd4, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd3, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd2, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd5, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd3, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd255, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    send_word(KIND_DATA, 8'd0, 32'h0, 6'd0);
    send_word(KIND_UNUSED, 8'd0, 32'h0, 6'd0);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);
    wait_for_bytes_out();

    // First phase: the sender idles now and then, the receiver most of the time.
    send_gap_pct   = 26;
    recv_stall_pct = 84;
    run_random_phase(PHASE_WORDS);
    wait_for_bytes_out();

    // Second phase: the other way round.
    send_gap_pct   = 84;
    recv_stall_pct = 26;
    run_random_phase(PHASE_WORDS);
    wait_for_bytes_out();

    // Third phase: no idling at all. It opens with a long receiver hold-off
    // while full-width codes keep arriving, so the output side backs up into
    // the item channel and the block has to stall its input.
    send_gap_pct   = 0;
    recv_stall_pct = 0;
    send_word(KIND_LOAD, 8'd200, $urandom, 6'd32);
    holds_asked++;
    repeat (16) send_word(KIND_DATA, 8'd200, $urandom, CODE_LEN_W'($urandom));
    run_random_phase(PHASE_WORDS);
    send_word(KIND_FLUSH, 8'd0, 32'h0, 6'd0);

    wait_for_bytes_out();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (packer_model.mismatch_count == 0 && packer_model.bytes_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== huffman_code_bit_packer_core.f =====
+incdir+hw/rtl
hw/rtl/hcbp_pkg.sv
hw/rtl/hcbp_item_if.sv
hw/rtl/hcbp_result_if.sv
hw/rtl/hcbp_table.sv
hw/rtl/huffman_code_bit_packer_core.sv
sim/tb.sv
